FILE: src/fragment_composite_resolve_top_macros.svh
// Assertion macros shared by the fragment resolve block.
// FCR_ASSERT_IMPL checks that cons holds in the same cycle as ante.
// FCR_ASSERT_NEXT checks that cons holds in the cycle after ante.
`ifndef FRAGMENT_COMPOSITE_RESOLVE_TOP_MACROS_SVH
`define FRAGMENT_COMPOSITE_RESOLVE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FCR_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fcr: same-cycle check failed");
`define FCR_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fcr: next-cycle check failed");
`else
`define FCR_ASSERT_IMPL(label, ck, rn, ante, cons)
`define FCR_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

FILE: src/fcr_pkg.sv
package fcr_pkg;

    // Fixed widths of the payload.
    localparam int Q_W        = 16;
    localparam int DEPTH_W    = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Q1.15 constants and the far depth sentinel.
    localparam logic [Q_W-1:0]     Q_ONE     = 16'h8000;
    localparam logic [31:0]        Q_HALF    = 32'h0000_4000;
    localparam logic [DEPTH_W-1:0] DEPTH_FAR = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_RED   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_GREEN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_BLUE  = 4'd3;

    typedef enum logic [1:0] {
        DM_MIN = 2'd0,
        DM_MID = 2'd1,
        DM_MAX = 2'd2,
        DM_AVG = 2'd3
    } depth_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic upd;        // fold the accepted fragment into the sample state
        logic cfg_we;     // write a configuration register
        logic div_start;  // start the average division
        logic load_out;   // load the result register and clear the sample
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_busy;
    } sts_t;

endpackage

FILE: src/fcr_if.sv
// Fragment input channel.
interface fcr_frag_if import fcr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [Q_W-1:0]     col_red;
    logic [Q_W-1:0]     col_green;
    logic [Q_W-1:0]     col_blue;
    logic [Q_W-1:0]     opa_red;
    logic [Q_W-1:0]     opa_green;
    logic [Q_W-1:0]     opa_blue;
    logic [DEPTH_W-1:0] frag_depth;
    logic               is_matte;
    logic               occludes;
    logic               last_frag;

    modport source (
        output valid, col_red, col_green, col_blue, opa_red, opa_green, opa_blue,
               frag_depth, is_matte, occludes, last_frag,
        input  ready
    );
    modport sink (
        input  valid, col_red, col_green, col_blue, opa_red, opa_green, opa_blue,
               frag_depth, is_matte, occludes, last_frag,
        output ready
    );
endinterface

// Resolved sample output channel.
interface fcr_res_if import fcr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [Q_W-1:0]     res_red;
    logic [Q_W-1:0]     res_green;
    logic [Q_W-1:0]     res_blue;
    logic [Q_W-1:0]     res_opa_red;
    logic [Q_W-1:0]     res_opa_green;
    logic [Q_W-1:0]     res_opa_blue;
    logic [DEPTH_W-1:0] res_depth;

    modport source (
        output valid, res_red, res_green, res_blue, res_opa_red, res_opa_green,
               res_opa_blue, res_depth,
        input  ready
    );
    modport sink (
        input  valid, res_red, res_green, res_blue, res_opa_red, res_opa_green,
               res_opa_blue, res_depth,
        output ready
    );
endinterface

// Configuration write channel.
interface fcr_cfg_if import fcr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/fcr_div.sv
// Restoring divider, one quotient bit per cycle.
module fcr_div import fcr_pkg::*; #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  q_bit;

    // One trial subtraction of the shifted remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor};
        q_bit = (trial >= {1'b0, divisor});
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            quo_next = {quo_reg[DIVIDEND_W-2:0], q_bit};
            rem_next = q_bit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

FILE: src/fcr_datapath.sv
// Blend, depth tracking, depth filter and result register.
module fcr_datapath import fcr_pkg::*; #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [Q_W-1:0]        col_red,
    input  logic [Q_W-1:0]        col_green,
    input  logic [Q_W-1:0]        col_blue,
    input  logic [Q_W-1:0]        opa_red,
    input  logic [Q_W-1:0]        opa_green,
    input  logic [Q_W-1:0]        opa_blue,
    input  logic [DEPTH_W-1:0]    frag_depth,
    input  logic                  is_matte,
    input  logic                  occludes,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [Q_W-1:0]        res_red,
    output logic [Q_W-1:0]        res_green,
    output logic [Q_W-1:0]        res_blue,
    output logic [Q_W-1:0]        res_opa_red,
    output logic [Q_W-1:0]        res_opa_green,
    output logic [Q_W-1:0]        res_opa_blue,
    output logic [DEPTH_W-1:0]    res_depth
);

    localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
    localparam int SUM_W = DEPTH_W + CNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAGMENTS);

    // Round-half-up Q1.15 product.
    function automatic logic [Q_W:0] mul_q(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        logic [31:0] p;
        p = a * b + Q_HALF;
        return p[31:15];
    endfunction

    function automatic logic [Q_W-1:0] sat_in(input logic [Q_W-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    function automatic logic [Q_W-1:0] sat_sum(input logic [Q_W+1:0] v);
        return (v > {2'b00, Q_ONE}) ? Q_ONE : v[Q_W-1:0];
    endfunction

    // Configuration registers.
    depth_mode_t    depth_mode_reg;
    logic [Q_W-1:0] thresh_reg [3];

    // Sample state.
    logic [Q_W-1:0]     acc_col_reg [3];
    logic [Q_W-1:0]     acc_opa_reg [3];
    logic [DEPTH_W-1:0] nearest_reg;
    logic [DEPTH_W-1:0] second_reg;
    logic [DEPTH_W-1:0] farthest_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   opaque_cnt_reg;
    logic [CNT_W-1:0]   frag_cnt_reg;

    // Result register.
    logic [Q_W-1:0]     res_col_reg [3];
    logic [Q_W-1:0]     res_opa_reg [3];
    logic [DEPTH_W-1:0] res_depth_reg;

    logic [Q_W-1:0]     col_in [3];
    logic [Q_W-1:0]     opa_in [3];
    logic [Q_W-1:0]     col_s [3];
    logic [Q_W-1:0]     opa_s [3];
    logic [Q_W-1:0]     col_next [3];
    logic [Q_W-1:0]     opa_next [3];
    logic               opaque;
    logic [DEPTH_W:0]   mid_sum;
    logic [DEPTH_W-1:0] depth_sel;
    logic [SUM_W-1:0]   quotient;
    logic               div_busy;

    assign col_in[0] = col_red;
    assign col_in[1] = col_green;
    assign col_in[2] = col_blue;
    assign opa_in[0] = opa_red;
    assign opa_in[1] = opa_green;
    assign opa_in[2] = opa_blue;

    // Per-channel blend; one multiplier for color and two for opacity, selected by is_matte.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [Q_W-1:0] inv;
            logic [Q_W:0]   mc;
            logic [Q_W:0]   ma;
            col_s[ch] = sat_in(col_in[ch]);
            opa_s[ch] = sat_in(opa_in[ch]);
            inv = Q_ONE - opa_s[ch];
            mc  = mul_q(acc_col_reg[ch], inv);
            ma  = is_matte ? mul_q(acc_opa_reg[ch], inv)
                           : mul_q(Q_ONE - acc_opa_reg[ch], opa_s[ch]);
            if (is_matte && occludes)
            begin
                col_next[ch] = '0;
                opa_next[ch] = '0;
            end
            else if (is_matte)
            begin
                col_next[ch] = mc[Q_W-1:0];
                opa_next[ch] = ma[Q_W-1:0];
            end
            else
            begin
                col_next[ch] = sat_sum({1'b0, mc} + {2'b00, col_s[ch]});
                opa_next[ch] = sat_sum({1'b0, ma} + {2'b00, acc_opa_reg[ch]});
            end
        end
    end

    assign opaque = (opa_s[0] >= thresh_reg[0]) || (opa_s[1] >= thresh_reg[1])
                 || (opa_s[2] >= thresh_reg[2]);

    // Depth filter over the finished sample.
    assign mid_sum = {1'b0, nearest_reg} + {1'b0, second_reg};

    always_comb
    begin
        case (depth_mode_reg)
            DM_MIN: depth_sel = nearest_reg;
            DM_MID: depth_sel = (frag_cnt_reg > CNT_W'(1)) ? mid_sum[DEPTH_W:1] : DEPTH_FAR;
            DM_MAX: depth_sel = farthest_reg;
            DM_AVG: depth_sel = (opaque_cnt_reg != '0) ? quotient[DEPTH_W-1:0] : DEPTH_FAR;
            default: depth_sel = nearest_reg;
        endcase
    end

    fcr_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (opaque_cnt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign sts.need_div = (depth_mode_reg == DM_AVG) && (opaque_cnt_reg != '0);
    assign sts.div_busy = div_busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= DM_MIN;
            for (int ch = 0; ch < 3; ch++)
            begin
                thresh_reg[ch] <= Q_ONE;
            end
        end
        else if (cmd.cfg_we)
        begin
            case (cfg_index)
                CFG_DEPTH_MODE:   depth_mode_reg <= depth_mode_t'(cfg_data[1:0]);
                CFG_THRESH_RED:   thresh_reg[0] <= cfg_data;
                CFG_THRESH_GREEN: thresh_reg[1] <= cfg_data;
                CFG_THRESH_BLUE:  thresh_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sample state: folded on each fragment, cleared when the result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                acc_col_reg[ch] <= '0;
                acc_opa_reg[ch] <= '0;
            end
            nearest_reg    <= DEPTH_FAR;
            second_reg     <= DEPTH_FAR;
            farthest_reg   <= DEPTH_FAR;
            sum_reg        <= '0;
            opaque_cnt_reg <= '0;
            frag_cnt_reg   <= '0;
        end
        else if (cmd.load_out)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                acc_col_reg[ch] <= '0;
                acc_opa_reg[ch] <= '0;
            end
            nearest_reg    <= DEPTH_FAR;
            second_reg     <= DEPTH_FAR;
            farthest_reg   <= DEPTH_FAR;
            sum_reg        <= '0;
            opaque_cnt_reg <= '0;
            frag_cnt_reg   <= '0;
        end
        else if (cmd.upd)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                acc_col_reg[ch] <= col_next[ch];
                acc_opa_reg[ch] <= opa_next[ch];
            end
            if (opaque)
            begin
                second_reg  <= nearest_reg;
                nearest_reg <= frag_depth;
                if (farthest_reg == DEPTH_FAR)
                begin
                    farthest_reg <= frag_depth;
                end
                if (opaque_cnt_reg < CNT_MAX)
                begin
                    opaque_cnt_reg <= opaque_cnt_reg + CNT_W'(1);
                    sum_reg        <= sum_reg + SUM_W'(frag_depth);
                end
            end
            if (frag_cnt_reg < CNT_MAX)
            begin
                frag_cnt_reg <= frag_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                res_col_reg[ch] <= acc_col_reg[ch];
                res_opa_reg[ch] <= acc_opa_reg[ch];
            end
            res_depth_reg <= depth_sel;
        end
    end

    assign res_red       = res_col_reg[0];
    assign res_green     = res_col_reg[1];
    assign res_blue      = res_col_reg[2];
    assign res_opa_red   = res_opa_reg[0];
    assign res_opa_green = res_opa_reg[1];
    assign res_opa_blue  = res_opa_reg[2];
    assign res_depth     = res_depth_reg;

endmodule

FILE: src/fcr_ctrl.sv
// Sequencer for fragment intake, sample resolve and result handoff.
module fcr_ctrl import fcr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic frag_valid,
    input  logic frag_last,
    output logic frag_ready,
    input  logic cfg_valid,
    output logic cfg_ready,
    output logic res_valid,
    input  logic res_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;
    logic   frag_acc;

    assign out_free = !res_valid_reg || res_ready;
    assign frag_acc = frag_valid && frag_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frag_acc && frag_last)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = sts.need_div ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd        = '0;
        frag_ready = 1'b0;
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        case (state_reg)
            ST_IDLE:
            begin
                frag_ready = 1'b1;
                cmd.upd    = frag_valid;
            end
            ST_RESOLVE:
            begin
                cmd.div_start = sts.need_div;
            end
            ST_DIV: ;
            ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default: ;
        endcase
    end

    // The result word stays valid until it is taken.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

FILE: src/fragment_composite_resolve_top.sv
// Back-to-front compositor for one sample: fragment words arrive farthest first, one per
// cycle, and are blended into running Q1.15 color and opacity while opaque depths are
// tracked. The word flagged last_frag closes the sample; the block then stops taking
// fragments, selects the depth by depth_mode and places one result word on res. After the
// last fragment is taken the sequencer passes through its resolve and finish states; in
// finish it loads the result register, from which res valid is registered, and returns
// to idle to take the next fragment. In average mode with at least one opaque fragment a
// div state lies between resolve and finish, in which the restoring divider works out one
// quotient bit per cycle. If the previous result word has not been taken yet, the load
// and the next fragment wait until it is. A new sample may start as soon as the result
// is loaded, while that word still waits to be taken. Configuration writes are accepted
// in every cycle and must only be issued while the block is idle.
`include "fragment_composite_resolve_top_macros.svh"

module fragment_composite_resolve_top import fcr_pkg::*; #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    fcr_frag_if.sink   frag,
    fcr_res_if.source  res,
    fcr_cfg_if.sink    cfg
);

    cmd_t cmd;
    sts_t sts;

    // Control.
    fcr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .frag_valid (frag.valid),
        .frag_last  (frag.last_frag),
        .frag_ready (frag.ready),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath.
    fcr_datapath #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .col_red       (frag.col_red),
        .col_green     (frag.col_green),
        .col_blue      (frag.col_blue),
        .opa_red       (frag.opa_red),
        .opa_green     (frag.opa_green),
        .opa_blue      (frag.opa_blue),
        .frag_depth    (frag.frag_depth),
        .is_matte      (frag.is_matte),
        .occludes      (frag.occludes),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .res_red       (res.res_red),
        .res_green     (res.res_green),
        .res_blue      (res.res_blue),
        .res_opa_red   (res.res_opa_red),
        .res_opa_green (res.res_opa_green),
        .res_opa_blue  (res.res_opa_blue),
        .res_depth     (res.res_depth)
    );

    // A loaded result is visible in the next cycle.
    `FCR_ASSERT_NEXT(a_load_shows_word, clk, rst_n, cmd.load_out, res.valid)
    // The result is never loaded while the division is still running.
    `FCR_ASSERT_IMPL(a_no_load_in_div, clk, rst_n, cmd.load_out, !sts.div_busy)
    // No fragment is taken while the division is running.
    `FCR_ASSERT_IMPL(a_no_frag_in_div, clk, rst_n, sts.div_busy, !frag.ready)

endmodule

FILE: dv/fcr_resolve_checker.sv
`timescale 1ns / 100ps

// Watches the fragment, result and configuration channels of the resolve block.
// It keeps its own copy of the sample state and configuration, works out the
// resolved pixel for every closing fragment word and checks each result word.
module fcr_resolve_checker import fcr_pkg::*; #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    fcr_frag_if  frag,
    fcr_res_if   res,
    fcr_cfg_if   cfg,
    output int   mismatches,
    output int   awaited
);

    typedef struct packed {
        logic [Q_W-1:0]     red;
        logic [Q_W-1:0]     green;
        logic [Q_W-1:0]     blue;
        logic [Q_W-1:0]     opa_red;
        logic [Q_W-1:0]     opa_green;
        logic [Q_W-1:0]     opa_blue;
        logic [DEPTH_W-1:0] depth;
    } pixel_t;

    // Configuration as last written.
    depth_mode_t    mode;
    logic [Q_W-1:0] thresh [3];

    // Running state of the sample being composited.
    logic [Q_W-1:0]     acc_col [3];
    logic [Q_W-1:0]     acc_opa [3];
    logic [DEPTH_W-1:0] near_z;
    logic [DEPTH_W-1:0] second_z;
    logic [DEPTH_W-1:0] far_z;
    logic [39:0]        z_sum;
    logic [7:0]         opaque_n;
    logic [7:0]         frag_n;

    // Resolved pixels still owed by the block, oldest first.
    pixel_t resolved_q [$];
    int     fail_n;

    function automatic logic [31:0] clamp_unit(input logic [31:0] v);
        return (v > 32'(Q_ONE)) ? 32'(Q_ONE) : v;
    endfunction

    // Q1.15 product, rounded half up.
    function automatic logic [31:0] q_mul(input logic [31:0] a, input logic [31:0] b);
        return (a * b + Q_HALF) >> 15;
    endfunction

    task automatic clear_sample();
        int i;

        for (i = 0; i < 3; i++)
        begin
            acc_col[i] = '0;
            acc_opa[i] = '0;
        end
        near_z   = DEPTH_FAR;
        second_z = DEPTH_FAR;
        far_z    = DEPTH_FAR;
        z_sum    = '0;
        opaque_n = '0;
        frag_n   = '0;
    endtask

    // Folds the accepted fragment word into the sample and, when it closes the
    // sample, returns the resolved pixel.
    task automatic composite_fragment(output bit done, output pixel_t px);
        logic [31:0]        col_in [3];
        logic [31:0]        opa_in [3];
        logic [31:0]        c;
        logic [31:0]        a;
        logic [31:0]        inv;
        logic [DEPTH_W:0]   mid;
        logic [39:0]        quo;
        logic [DEPTH_W-1:0] z;
        bit                 opaque;
        int                 i;

        col_in[0] = clamp_unit(32'(frag.col_red));
        col_in[1] = clamp_unit(32'(frag.col_green));
        col_in[2] = clamp_unit(32'(frag.col_blue));
        opa_in[0] = clamp_unit(32'(frag.opa_red));
        opa_in[1] = clamp_unit(32'(frag.opa_green));
        opa_in[2] = clamp_unit(32'(frag.opa_blue));
        z = frag.frag_depth;

        // Blend, clear or attenuate each channel; occludes only matters on a matte.
        for (i = 0; i < 3; i++)
        begin
            c   = 32'(acc_col[i]);
            a   = 32'(acc_opa[i]);
            inv = 32'(Q_ONE) - opa_in[i];
            if (frag.is_matte && frag.occludes)
            begin
                c = '0;
                a = '0;
            end
            else if (frag.is_matte)
            begin
                c = q_mul(c, inv);
                a = q_mul(a, inv);
            end
            else
            begin
                c = clamp_unit(q_mul(c, inv) + col_in[i]);
                a = clamp_unit(q_mul(32'(Q_ONE) - a, opa_in[i]) + a);
            end
            acc_col[i] = c[Q_W-1:0];
            acc_opa[i] = a[Q_W-1:0];
        end

        // Opaque depth tracking; the sum stops growing once the count saturates.
        opaque = (opa_in[0] >= 32'(thresh[0])) || (opa_in[1] >= 32'(thresh[1]))
                 || (opa_in[2] >= 32'(thresh[2]));
        if (opaque)
        begin
            second_z = near_z;
            near_z   = z;
            if (far_z == DEPTH_FAR)
                far_z = z;
            if (opaque_n < MAX_FRAGMENTS)
            begin
                opaque_n = opaque_n + 8'd1;
                z_sum    = z_sum + 40'(z);
            end
        end
        if (frag_n < MAX_FRAGMENTS)
            frag_n = frag_n + 8'd1;

        done = frag.last_frag;
        px   = '0;
        if (done)
        begin
            case (mode)
                DM_MID:
                begin
                    mid = {1'b0, near_z} + {1'b0, second_z};
                    px.depth = (frag_n > 8'd1) ? mid[DEPTH_W:1] : DEPTH_FAR;
                end
                DM_MAX:
                    px.depth = far_z;
                DM_AVG:
                begin
                    px.depth = DEPTH_FAR;
                    if (opaque_n != 0)
                    begin
                        quo = z_sum / 40'(opaque_n);
                        px.depth = quo[DEPTH_W-1:0];
                    end
                end
                default:
                    px.depth = near_z;
            endcase
            px.red       = acc_col[0];
            px.green     = acc_col[1];
            px.blue      = acc_col[2];
            px.opa_red   = acc_opa[0];
            px.opa_green = acc_opa[1];
            px.opa_blue  = acc_opa[2];
            clear_sample();
        end
    endtask

    task automatic check_field(input string name, input logic [DEPTH_W-1:0] want,
                               input logic [DEPTH_W-1:0] seen);
        if (seen !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            fail_n++;
        end
    endtask

    // All three channels are sampled at the clock edge that completes a handshake.
    always @(posedge clk or negedge rst_n)
    begin : watch
        bit     done;
        pixel_t fresh;
        pixel_t want;

        if (!rst_n)
        begin
            mode      = DM_MIN;
            thresh[0] = Q_ONE;
            thresh[1] = Q_ONE;
            thresh[2] = Q_ONE;
            clear_sample();
            resolved_q.delete();
            fail_n = 0;
            mismatches <= 0;
            awaited    <= 0;
        end
        else
        begin
            // Register writes; unknown indexes are ignored by the block.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_DEPTH_MODE:   mode = depth_mode_t'(cfg.data[1:0]);
                    CFG_THRESH_RED:   thresh[0] = cfg.data;
                    CFG_THRESH_GREEN: thresh[1] = cfg.data;
                    CFG_THRESH_BLUE:  thresh[2] = cfg.data;
                    default:          ;
                endcase
            end

            if (frag.valid && frag.ready)
            begin
                composite_fragment(done, fresh);
                if (done)
                    resolved_q.push_back(fresh);
            end

            // Each result word is matched against the oldest resolved pixel.
            if (res.valid && res.ready)
            begin
                if (resolved_q.size() == 0)
                begin
                    $error("result word with no sample pending: depth %0h", res.res_depth);
                    fail_n++;
                end
                else
                begin
                    want = resolved_q.pop_front();
                    check_field("res_red", want.red, res.res_red);
                    check_field("res_green", want.green, res.res_green);
                    check_field("res_blue", want.blue, res.res_blue);
                    check_field("res_opa_red", want.opa_red, res.res_opa_red);
                    check_field("res_opa_green", want.opa_green, res.res_opa_green);
                    check_field("res_opa_blue", want.opa_blue, res.res_opa_blue);
                    check_field("res_depth", want.depth, res.res_depth);
                end
            end

            mismatches <= fail_n;
            awaited    <= resolved_q.size();
        end
    end

endmodule

FILE: dv/tb_fragment_composite_resolve_top.sv
`timescale 1ns / 100ps

// Drives fragment words and register writes into the resolve block, applies
// back-pressure on the result channel and reports the outcome of the run.
module tb_fragment_composite_resolve_top;
    import fcr_pkg::*;

    localparam int MAX_FRAGMENTS   = 64;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 238;
    localparam int DRAIN_CYCLES    = 60;
    localparam int LONG_HOLD       = 300;
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef struct packed {
        logic [Q_W-1:0]     col_red;
        logic [Q_W-1:0]     col_green;
        logic [Q_W-1:0]     col_blue;
        logic [Q_W-1:0]     opa_red;
        logic [Q_W-1:0]     opa_green;
        logic [Q_W-1:0]     opa_blue;
        logic [DEPTH_W-1:0] depth;
        logic               matte;
        logic               occl;
        logic               closes;
    } fragment_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_style_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   awaited;
    logic hold_go;
    int   burst_left;
    int   cycle_n;

    fcr_frag_if frag_ch ();
    fcr_res_if  res_ch ();
    fcr_cfg_if  cfg_ch ();

    fragment_composite_resolve_top #(
        .MAX_FRAGMENTS(MAX_FRAGMENTS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .frag (frag_ch),
        .res  (res_ch),
        .cfg  (cfg_ch)
    );

    fcr_resolve_checker #(
        .MAX_FRAGMENTS(MAX_FRAGMENTS)
    ) resolve_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .frag      (frag_ch),
        .res       (res_ch),
        .cfg       (cfg_ch),
        .mismatches(mismatches),
        .awaited   (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic fragment_t frag_of(input logic [Q_W-1:0] c0, input logic [Q_W-1:0] c1,
                                          input logic [Q_W-1:0] c2, input logic [Q_W-1:0] a0,
                                          input logic [Q_W-1:0] a1, input logic [Q_W-1:0] a2,
                                          input logic [DEPTH_W-1:0] z, input bit m,
                                          input bit o, input bit l);
        fragment_t w;

        w.col_red   = c0;
        w.col_green = c1;
        w.col_blue  = c2;
        w.opa_red   = a0;
        w.opa_green = a1;
        w.opa_blue  = a2;
        w.depth     = z;
        w.matte     = m;
        w.occl      = o;
        w.closes    = l;
        return w;
    endfunction

    function automatic logic [Q_W-1:0] pick_color();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q_ONE;
            2:       return Q_W'($urandom_range(0, 65535));
            3:       return Q_ONE - Q_W'($urandom_range(1, 64));
            default: return Q_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [Q_W-1:0] pick_opacity();
        case ($urandom_range(0, 9))
            0, 1, 2: return Q_ONE;
            3:       return '0;
            4:       return Q_W'($urandom_range(0, 65535));
            5:       return Q_ONE - Q_W'($urandom_range(1, 512));
            default: return Q_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [DEPTH_W-1:0] pick_depth();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DEPTH_FAR;
            2:       return DEPTH_FAR - 1;
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    // Thresholds include zero, one, and values above one that are never met.
    function automatic logic [Q_W-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return Q_ONE;
            2:       return Q_W'(1);
            3:       return Q_W'($urandom_range(32769, 65535));
            4:       return Q_ONE - Q_W'(1);
            default: return Q_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // Long samples exercise saturation of the fragment and opaque counts.
    function automatic int sample_length();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom_range(1, 2);
        else if (pick < 85)
            return $urandom_range(3, 6);
        else if (pick < 98)
            return $urandom_range(7, 16);
        return $urandom_range(MAX_FRAGMENTS + 1, MAX_FRAGMENTS + 8);
    endfunction

    function automatic fragment_t random_fragment(input bit dense, input bit closes);
        fragment_t w;

        w.col_red   = pick_color();
        w.col_green = pick_color();
        w.col_blue  = pick_color();
        w.opa_red   = (dense && $urandom_range(0, 4) != 0) ? Q_ONE : pick_opacity();
        w.opa_green = pick_opacity();
        w.opa_blue  = pick_opacity();
        w.depth     = pick_depth();
        w.matte     = ($urandom_range(0, 5) == 0);
        w.occl      = ($urandom_range(0, 2) == 0);
        w.closes    = closes;
        return w;
    endfunction

    // Offers one fragment word and waits for it to be taken. Valid stays high
    // inside a burst; a gap lowers it for a random number of cycles.
    task automatic offer_fragment(input fragment_t w);
        int gap;

        frag_ch.valid      <= 1'b1;
        frag_ch.col_red    <= w.col_red;
        frag_ch.col_green  <= w.col_green;
        frag_ch.col_blue   <= w.col_blue;
        frag_ch.opa_red    <= w.opa_red;
        frag_ch.opa_green  <= w.opa_green;
        frag_ch.opa_blue   <= w.opa_blue;
        frag_ch.frag_depth <= w.depth;
        frag_ch.is_matte   <= w.matte;
        frag_ch.occludes   <= w.occl;
        frag_ch.last_frag  <= w.closes;
        do
            @(posedge clk);
        while (!frag_ch.ready);

        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 6);
            frag_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 24);
        end
    endtask

    task automatic send_sample(input int n, input bit dense);
        int i;

        for (i = 0; i < n; i++)
            offer_fragment(random_fragment(dense, i == n - 1));
    endtask

    // Leaves valid high so back-to-back writes need only one assignment per edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic program_config(input int k);
        depth_mode_t    m;
        logic [Q_W-1:0] th [3];
        int             i;

        m = depth_mode_t'(k % 4);
        for (i = 0; i < 3; i++)
        begin
            case (k)
                1:       th[i] = '0;
                2:       th[i] = 16'hFFFF;
                3:       th[i] = Q_ONE;
                default: th[i] = pick_threshold();
            endcase
        end
        // An unused index must not disturb any register.
        if ($urandom_range(0, 1) == 1)
            write_register(CFG_THRESH_BLUE + 4'd1 + CFG_IDX_W'($urandom_range(0, 11)),
                           CFG_DATA_W'($urandom));
        write_register(CFG_DEPTH_MODE, {14'($urandom), m});
        write_register(CFG_THRESH_RED, th[0]);
        write_register(CFG_THRESH_GREEN, th[1]);
        write_register(CFG_THRESH_BLUE, th[2]);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering words until every resolved pixel has come out, then
    // waits out DRAIN_CYCLES before the next phase.
    task automatic drain();
        frag_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: the stall style changes now and then, with one long hold-off.
    initial
    begin : sink_side
        sink_style_t style;
        int          style_left;
        int          hold_left;
        bit          hold_done;

        style      = SINK_OPEN;
        style_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (style_left == 0)
            begin
                style      = sink_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 150);
            end
            else
                style_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    SINK_OPEN:   res_ch.ready <= 1'b1;
                    SINK_COIN:   res_ch.ready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: res_ch.ready <= ($urandom_range(0, 7) == 0);
                    default:     res_ch.ready <= (style_left % 4 != 0);
                endcase
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        for (cycle_n = 0; cycle_n < CYCLE_LIMIT; cycle_n++)
            @(posedge clk);
        $display("fragment_composite_resolve_top verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int n;
        int k;

        rst_n              <= 1'b0;
        hold_go            <= 1'b0;
        burst_left          = 0;
        frag_ch.valid      <= 1'b0;
        frag_ch.col_red    <= '0;
        frag_ch.col_green  <= '0;
        frag_ch.col_blue   <= '0;
        frag_ch.opa_red    <= '0;
        frag_ch.opa_green  <= '0;
        frag_ch.opa_blue   <= '0;
        frag_ch.frag_depth <= '0;
        frag_ch.is_matte   <= 1'b0;
        frag_ch.occludes   <= 1'b0;
        frag_ch.last_frag  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset configuration.
        // Single opaque fragment at depth zero.
        offer_fragment(frag_of(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0, 0, 0, 1));
        // Colour and opacity above one, depth at the far sentinel.
        offer_fragment(frag_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               DEPTH_FAR, 0, 0, 1));
        // Clear fragment, occludes without matte, plain matte, matte occluder, then
        // a closing fragment with mixed channels.
        offer_fragment(frag_of('0, '0, '0, '0, '0, '0, 32'd1234, 0, 0, 0));
        offer_fragment(frag_of(16'd20000, 16'd12345, Q_ONE, 16'd16384, 16'd8192, Q_ONE,
                               32'h8000_0000, 0, 1, 0));
        offer_fragment(frag_of(16'd5000, 16'd5000, 16'd5000, 16'd16384, '0, 16'd32767,
                               32'd777, 1, 0, 0));
        offer_fragment(frag_of(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'd42, 1, 1, 0));
        offer_fragment(frag_of(Q_ONE, '0, 16'd12345, '0, Q_ONE, 16'd40000,
                               DEPTH_FAR - 1, 0, 0, 1));
        // Colour saturation through two fully transparent white fragments.
        offer_fragment(frag_of(Q_ONE, Q_ONE, Q_ONE, '0, '0, '0, 32'd5, 0, 0, 0));
        offer_fragment(frag_of(Q_ONE, Q_ONE, Q_ONE, '0, '0, '0, 32'd6, 0, 0, 1));
        // No opaque fragment at all.
        offer_fragment(frag_of(16'd100, 16'd200, 16'd300, 16'd100, 16'd32767, '0,
                               32'd999, 0, 0, 1));
        // Alternating bit patterns.
        offer_fragment(frag_of(16'h5555, 16'hAAAA, 16'h7FFF, 16'h2AAA, 16'h5555, 16'h7FFF,
                               32'hAAAA_5555, 0, 0, 0));
        offer_fragment(frag_of(16'hAAAA, 16'h5555, 16'h0001, 16'hD555, 16'h2AAA, 16'h0001,
                               32'h5555_AAAA, 1, 0, 1));
        drain();

        // Random phases, each under its own register setting.
        for (k = 1; k <= PHASES; k++)
        begin
            program_config(k);
            if (k == 3)
                hold_go <= 1'b1;
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                n = sample_length();
                send_sample(n, n > 16);
                sent += n;
            end
            drain();
        end

        @(negedge clk);
        if (awaited != 0)
            $error("%0d resolved pixels never came out", awaited);
        if (mismatches == 0 && awaited == 0)
            $display("fragment_composite_resolve_top verification clean");
        else
            $display("fragment_composite_resolve_top verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/fcr_pkg.sv
src/fcr_if.sv
src/fcr_div.sv
src/fcr_datapath.sv
src/fcr_ctrl.sv
src/fragment_composite_resolve_top.sv
dv/fcr_resolve_checker.sv
dv/tb_fragment_composite_resolve_top.sv
